[rtl/prce_pkg.sv]
`default_nettype none

package prce_pkg;

	localparam int NUM_CHIPS_DEF = 3;
	localparam int ENTRIES_DEF   = 4096;

	localparam int KIND_W     = 2;
	localparam int CHIP_W     = 2;
	localparam int DATA_W     = 16;
	localparam int ADDR_W     = 12;
	localparam int INDEX_W    = 14;
	localparam int COMP_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;

	typedef logic [KIND_W-1:0]     kind_t;
	typedef logic [CFG_DATA_W-1:0] fmt_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	localparam kind_t KIND_READ = 2'd0;
	localparam kind_t KIND_ADDR = 2'd1;
	localparam kind_t KIND_DATA = 2'd2;

	localparam fmt_t FMT_RGB5 = 2'd0;
	localparam fmt_t FMT_RGB4 = 2'd1;
	localparam fmt_t FMT_BGR5 = 2'd2;

	localparam cfg_idx_t REG_STEP_MODE = 1'd0;
	localparam cfg_idx_t REG_COLOR_FMT = 1'd1;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} rgb_t;

	function automatic logic [COMP_W-1:0] expand5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [COMP_W-1:0] expand4(input logic [3:0] v);
		return {v, v};
	endfunction

	function automatic rgb_t decode_color(input fmt_t fmt, input logic [DATA_W-1:0] d);
		rgb_t c;
		case (fmt)
			FMT_RGB4: begin
				c.red   = expand4(d[3:0]);
				c.green = expand4(d[7:4]);
				c.blue  = expand4(d[11:8]);
			end
			FMT_BGR5: begin
				c.red   = expand5(d[14:10]);
				c.green = expand5(d[9:5]);
				c.blue  = expand5(d[4:0]);
			end
			default: begin
				c.red   = expand5(d[4:0]);
				c.green = expand5(d[9:5]);
				c.blue  = expand5(d[14:10]);
			end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/prce_in_if.sv]
`default_nettype none

interface prce_in_if import prce_pkg::*; ();
	logic                valid;
	logic                ready;
	kind_t               kind;
	logic [CHIP_W-1:0]   chip;
	logic [DATA_W-1:0]   bus_data;

	modport source (output valid, kind, chip, bus_data, input ready);
	modport sink   (input valid, kind, chip, bus_data, output ready);
endinterface

`default_nettype wire

[rtl/prce_out_if.sv]
`default_nettype none

interface prce_out_if import prce_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [DATA_W-1:0]    read_word;
	logic                 color_valid;
	logic [INDEX_W-1:0]   color_index;
	logic [COMP_W-1:0]    red;
	logic [COMP_W-1:0]    green;
	logic [COMP_W-1:0]    blue;

	modport source (output valid, read_word, color_valid, color_index, red, green, blue,
		input ready);
	modport sink   (input valid, read_word, color_valid, color_index, red, green, blue,
		output ready);
endinterface

`default_nettype wire

[rtl/prce_ram.sv]
`default_nettype none

module prce_ram import prce_pkg::*; #(
	parameter int DEPTH = NUM_CHIPS_DEF * ENTRIES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [DATA_W-1:0]        wdata,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem[addr] <= wdata;
			else
				rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

[rtl/prce_mod.sv]
`default_nettype none

// addr % ENTRIES_PER_CHIP by exact reciprocal: q = (addr * ceil(2^24/E)) >> 24
module prce_mod import prce_pkg::*; #(
	parameter int ENTRIES_PER_CHIP = ENTRIES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [ADDR_W-1:0]                   addr,
	output logic                                     done,
	output logic      [$clog2(ENTRIES_PER_CHIP)-1:0] eff
);

	localparam int     EFF_W   = $clog2(ENTRIES_PER_CHIP);
	localparam int     SHIFT   = 2 * ADDR_W;
	localparam longint RECIP   = ((64'd1 << SHIFT) + ENTRIES_PER_CHIP - 1) / ENTRIES_PER_CHIP;
	localparam int     RECIP_W = SHIFT - 3;
	localparam int     PROD_W  = ADDR_W + RECIP_W;
	localparam int     Q_W     = PROD_W - SHIFT;
	localparam int     QE_W    = Q_W + ADDR_W + 1;

	logic [PROD_W-1:0] prod;
	logic [Q_W-1:0]    q_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              v_s1;
	logic [QE_W-1:0]   qe;
	logic [ADDR_W-1:0] rem;

	assign prod = PROD_W'(addr) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_s1    <= prod[PROD_W-1:SHIFT];
			addr_s1 <= addr;
		end
	end

	assign qe   = QE_W'(q_s1) * QE_W'(ENTRIES_PER_CHIP);
	assign rem  = addr_s1 - qe[ADDR_W-1:0];
	assign eff  = rem[EFF_W-1:0];
	assign done = v_s1;

endmodule

`default_nettype wire

[rtl/palette_ram_color_expander.sv]
// Palette RAM colour expander: NUM_CHIPS palette chips, each with a latched address and
// ENTRIES_PER_CHIP 16-bit words, all held in one single-port RAM. After reset the RAM is
// swept to zero, one word a cycle, over NUM_CHIPS * ENTRIES_PER_CHIP words (12288 by
// default); no transaction is taken meanwhile, configuration writes are. Then one access
// is handled at a time: a data write passes through the execute state; a read adds a read
// state for the RAM read latency; an address write adds a modulo state that waits on the
// two-stage modulo unit that maps the address onto the chip's RAM. The result sits in an
// output register, so the next access is taken while it waits to be accepted.
`default_nettype none

module palette_ram_color_expander import prce_pkg::*; #(
	parameter int NUM_CHIPS        = NUM_CHIPS_DEF,
	parameter int ENTRIES_PER_CHIP = ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	prce_in_if.sink                    in_ch,
	prce_out_if.source                 out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = NUM_CHIPS * ENTRIES_PER_CHIP;
	localparam int MAW   = $clog2(DEPTH);
	localparam int EFF_W = $clog2(ENTRIES_PER_CHIP);
	localparam int SEL_W = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_READ,
		S_MOD
	} state_t;

	state_t              state_q;
	logic [MAW-1:0]      clr_q;
	kind_t               kind_q;
	logic [CHIP_W-1:0]   chip_q;
	logic [DATA_W-1:0]   data_q;
	logic                step_mode_q;
	fmt_t                fmt_q;
	logic [EFF_W-1:0]    eff_q [NUM_CHIPS];

	logic                out_valid_q;
	logic [DATA_W-1:0]   read_word_q;
	logic                color_valid_q;
	logic [INDEX_W-1:0]  color_index_q;
	rgb_t                rgb_q;

	logic                chip_ok;
	logic [SEL_W-1:0]    chip_sel;
	logic [EFF_W-1:0]    cur_eff;
	logic [MAW-1:0]      slot;
	logic [ADDR_W-1:0]   new_addr;
	rgb_t                rgb;
	logic                out_free;
	logic                exec_go;
	logic                clearing;
	logic                ram_en;
	logic                ram_we;
	logic [MAW-1:0]      ram_addr;
	logic [DATA_W-1:0]   ram_wdata;
	logic [DATA_W-1:0]   ram_rdata;
	logic                mod_start;
	logic                mod_done;
	logic [EFF_W-1:0]    mod_eff;
	logic                out_load;
	logic [DATA_W-1:0]   nxt_read_word;
	logic                nxt_color_valid;
	logic [INDEX_W-1:0]  nxt_color_index;
	rgb_t                nxt_rgb;

	assign chip_ok  = {1'b0, chip_q} < 3'(NUM_CHIPS);
	assign chip_sel = chip_q[SEL_W-1:0];
	assign cur_eff  = chip_ok ? eff_q[chip_sel] : '0;
	assign slot     = MAW'(int'(chip_sel) * ENTRIES_PER_CHIP) + MAW'(cur_eff);
	assign new_addr = step_mode_q ? data_q[ADDR_W-1:0] : data_q[ADDR_W:1];
	assign rgb      = decode_color(fmt_q, data_q);

	assign out_free = !out_valid_q || out_ch.ready;
	assign exec_go  = (state_q == S_EXEC) && out_free;
	assign clearing = (state_q == S_CLEAR);

	assign ram_en    = clearing ||
		(exec_go && chip_ok && (kind_q == KIND_READ || kind_q == KIND_DATA));
	assign ram_we    = clearing || (exec_go && chip_ok && kind_q == KIND_DATA);
	assign ram_addr  = clearing ? clr_q : slot;
	assign ram_wdata = clearing ? '0 : data_q;
	assign mod_start = exec_go && chip_ok && kind_q == KIND_ADDR;

	assign out_load = (exec_go && !(chip_ok && kind_q == KIND_READ)) || (state_q == S_READ);

	always_comb begin
		nxt_read_word   = '0;
		nxt_color_valid = 1'b0;
		nxt_color_index = '0;
		nxt_rgb         = '0;
		if (state_q == S_READ) begin
			nxt_read_word = ram_rdata;
		end else if (chip_ok && kind_q == KIND_DATA) begin
			nxt_color_valid = 1'b1;
			nxt_color_index = {chip_q, ADDR_W'(cur_eff)};
			nxt_rgb         = rgb;
		end
	end

	prce_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	prce_mod #(
		.ENTRIES_PER_CHIP(ENTRIES_PER_CHIP)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.addr  (new_addr),
		.done  (mod_done),
		.eff   (mod_eff)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			kind_q        <= KIND_READ;
			chip_q        <= '0;
			data_q        <= '0;
			step_mode_q   <= 1'b0;
			fmt_q         <= FMT_RGB5;
			eff_q         <= '{default: '0};
			out_valid_q   <= 1'b0;
			read_word_q   <= '0;
			color_valid_q <= 1'b0;
			color_index_q <= '0;
			rgb_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP_MODE: step_mode_q <= cfg_data[0];
					REG_COLOR_FMT: fmt_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q   <= 1'b1;
				read_word_q   <= nxt_read_word;
				color_valid_q <= nxt_color_valid;
				color_index_q <= nxt_color_index;
				rgb_q         <= nxt_rgb;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAW'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_ch.valid) begin
						kind_q  <= in_ch.kind;
						chip_q  <= in_ch.chip;
						data_q  <= in_ch.bus_data;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						if (chip_ok && kind_q == KIND_READ)
							state_q <= S_READ;
						else if (chip_ok && kind_q == KIND_ADDR)
							state_q <= S_MOD;
						else
							state_q <= S_IDLE;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				S_MOD: begin
					if (mod_done) begin
						eff_q[chip_sel] <= mod_eff;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.read_word   = read_word_q;
	assign out_ch.color_valid = color_valid_q;
	assign out_ch.color_index = color_index_q;
	assign out_ch.red         = rgb_q.red;
	assign out_ch.green       = rgb_q.green;
	assign out_ch.blue        = rgb_q.blue;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ch.ready))
		else $error("result overwritten before transaction completed");

	a_ram_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_EXEC))
		else $error("RAM written outside clear sweep or execute");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> out_valid_q)
		else $error("read data not presented after RAM latency");

	a_mod_owned: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == S_MOD))
		else $error("modulo result arrived outside address update");

endmodule

`default_nettype wire

[bench/palette_ram_color_expander_tb.sv]
`timescale 1ns / 100ps

module palette_ram_color_expander_tb;
	import prce_pkg::*;

	localparam kind_t             KIND_SPARE     = 2'd3;
	localparam fmt_t              FMT_SPARE      = 2'd3;
	localparam logic [CHIP_W-1:0] CHIP_ABSENT    = 2'd3;
	localparam logic [1:0]        ADDR_FROM_HIGH = 2'd0;
	localparam logic [1:0]        ADDR_FROM_LOW  = 2'd1;
	localparam int                RAM_WORDS      = NUM_CHIPS_DEF * ENTRIES_DEF;
	localparam int                SLOT_W         = $clog2(RAM_WORDS);
	localparam int                HOLD_CYCLES    = 400;
	localparam int                PHASE_ITEMS    = 100;
	localparam int                REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [DATA_W-1:0]  read_word;
		logic               color_valid;
		logic [INDEX_W-1:0] color_index;
		logic [COMP_W-1:0]  red;
		logic [COMP_W-1:0]  green;
		logic [COMP_W-1:0]  blue;
	} palette_result_t;

	typedef struct {
		bit              pinned;
		palette_result_t want;
	} pinned_want_t;

	typedef struct {
		logic [1:0]        step;
		fmt_t              fmt;
		kind_t             kind;
		logic [CHIP_W-1:0] chip;
		logic [DATA_W-1:0] data;
		bit                pinned;
		palette_result_t   want;
	} probe_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	prce_in_if  in_ch ();
	prce_out_if out_ch ();

	palette_ram_color_expander dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [DATA_W-1:0] shadow_ram [0:RAM_WORDS-1];
	logic [ADDR_W-1:0] shadow_addr [0:NUM_CHIPS_DEF-1];
	logic [1:0]        step_written;
	fmt_t              fmt_written;

	palette_result_t pending_results[$];
	pinned_want_t    pinned_wants[$];
	probe_row_t      probes[$];
	int              fault_count;
	bit              no_idle;
	bit              hold_req;

	function automatic logic [COMP_W-1:0] widen5(input logic [4:0] v);
		return {v, 3'b000} | {5'b00000, v[4:2]};
	endfunction

	function automatic logic [COMP_W-1:0] widen4(input logic [3:0] v);
		return {v, 4'b0000} | {4'b0000, v};
	endfunction

	function automatic palette_result_t predict_access(input kind_t k,
			input logic [CHIP_W-1:0] c, input logic [DATA_W-1:0] d);
		palette_result_t r;
		logic [ADDR_W-1:0] eff;
		logic [SLOT_W-1:0] slot;
		r = '0;
		if (c >= NUM_CHIPS_DEF || k == KIND_SPARE)
			return r;
		eff = ADDR_W'(shadow_addr[c] % ENTRIES_DEF);
		slot = SLOT_W'(c * ENTRIES_DEF + eff);
		case (k)
			KIND_READ: begin
				r.read_word = shadow_ram[slot];
			end
			KIND_ADDR: begin
				shadow_addr[c] = step_written[0] ? d[11:0] : d[12:1];
			end
			default: begin
				shadow_ram[slot] = d;
				r.color_valid = 1'b1;
				r.color_index = INDEX_W'(c * ENTRIES_DEF + eff);
				case (fmt_written)
					FMT_RGB4: begin
						r.red   = widen4(d[3:0]);
						r.green = widen4(d[7:4]);
						r.blue  = widen4(d[11:8]);
					end
					FMT_BGR5: begin
						r.red   = widen5(d[14:10]);
						r.green = widen5(d[9:5]);
						r.blue  = widen5(d[4:0]);
					end
					default: begin
						r.red   = widen5(d[4:0]);
						r.green = widen5(d[9:5]);
						r.blue  = widen5(d[14:10]);
					end
				endcase
			end
		endcase
		return r;
	endfunction

	function automatic void add_probe(input logic [1:0] step, input fmt_t fmt, input kind_t k,
			input logic [CHIP_W-1:0] c, input logic [DATA_W-1:0] d, input bit pinned,
			input palette_result_t want);
		probe_row_t row;
		row.step   = step;
		row.fmt    = fmt;
		row.kind   = k;
		row.chip   = c;
		row.data   = d;
		row.pinned = pinned;
		row.want   = want;
		probes.push_back(row);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** palette_ram_color_expander: FAILED **");
		$finish;
	end

	// transaction checker: prediction on input acceptance, comparison on output acceptance
	always @(posedge clk) begin : scoreboard
		palette_result_t got;
		palette_result_t want;
		pinned_want_t    tag;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			want = predict_access(in_ch.kind, in_ch.chip, in_ch.bus_data);
			tag = pinned_wants.pop_front();
			pending_results.push_back(tag.pinned ? tag.want : want);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.read_word, out_ch.color_valid, out_ch.color_index,
				out_ch.red, out_ch.green, out_ch.blue};
			if (pending_results.size() == 0) begin
				if (fault_count < REPORT_LIMIT)
					$display("unexpected transaction: word %h valid %b index %h rgb %h %h %h",
						got.read_word, got.color_valid, got.color_index,
						got.red, got.green, got.blue);
				fault_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.read_word !== want.read_word || got.color_valid !== want.color_valid ||
						got.color_index !== want.color_index || got.red !== want.red ||
						got.green !== want.green || got.blue !== want.blue) begin
					if (fault_count < REPORT_LIMIT) begin
						$write("mismatch: exp word %h valid %b index %h rgb %h %h %h",
							want.read_word, want.color_valid, want.color_index,
							want.red, want.green, want.blue);
						$display(" / got word %h valid %b index %h rgb %h %h %h",
							got.read_word, got.color_valid, got.color_index,
							got.red, got.green, got.blue);
					end
					fault_count++;
				end
			end
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin : result_sink
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 22);
			end
		end
	end

	task automatic offer_access(input kind_t k, input logic [CHIP_W-1:0] c,
			input logic [DATA_W-1:0] d, input bit pinned, input palette_result_t want);
		pinned_want_t tag;
		if (!no_idle && $urandom_range(0, 99) < 22) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		tag.pinned = pinned;
		tag.want = want;
		pinned_wants.push_back(tag);
		in_ch.valid    <= 1'b1;
		in_ch.kind     <= k;
		in_ch.chip     <= c;
		in_ch.bus_data <= d;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0 || pinned_wants.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [1:0] step, input fmt_t fmt);
		cfg_we    <= 1'b1;
		cfg_index <= REG_STEP_MODE;
		cfg_data  <= step;
		@(posedge clk);
		cfg_index <= REG_COLOR_FMT;
		cfg_data  <= fmt;
		@(posedge clk);
		cfg_we <= 1'b0;
		step_written = step;
		fmt_written = fmt;
	endtask

	initial begin : stimulus
		kind_t             k;
		logic [CHIP_W-1:0] c;
		logic [DATA_W-1:0] d;
		logic [ADDR_W-1:0] a;
		logic [1:0]        step;
		fmt_t              fmt;
		int                pick;
		int                counted;

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= REG_STEP_MODE;
		cfg_data       <= '0;
		in_ch.valid    <= 1'b0;
		in_ch.kind     <= KIND_READ;
		in_ch.chip     <= '0;
		in_ch.bus_data <= '0;
		no_idle      = 1'b0;
		hold_req     = 1'b0;
		fault_count  = 0;
		step_written = ADDR_FROM_HIGH;
		fmt_written  = FMT_RGB5;
		foreach (shadow_ram[i])
			shadow_ram[i] = '0;
		foreach (shadow_addr[i])
			shadow_addr[i] = '0;

		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_READ, 2'd0, 16'h0000, 1, '0);
		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_READ, 2'd2, 16'hffff, 1, '0);
		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_DATA, CHIP_ABSENT, 16'hffff, 1, '0);
		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_SPARE, 2'd0, 16'hffff, 1, '0);
		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_ADDR, 2'd0, 16'h0000, 1, '0);
		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_DATA, 2'd0, 16'hffff, 1,
			{16'h0000, 1'b1, 14'h0000, 24'hffffff});
		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_READ, 2'd0, 16'h0000, 1,
			{16'hffff, 1'b0, 14'h0000, 24'h000000});
		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_DATA, 2'd0, 16'h0000, 1,
			{16'h0000, 1'b1, 14'h0000, 24'h000000});
		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_ADDR, 2'd1, 16'hffff, 1, '0);
		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_DATA, 2'd1, 16'h7fff, 1,
			{16'h0000, 1'b1, 14'h1fff, 24'hffffff});
		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_READ, 2'd1, 16'h0000, 1,
			{16'h7fff, 1'b0, 14'h0000, 24'h000000});
		add_probe(ADDR_FROM_HIGH, FMT_RGB5, KIND_DATA, 2'd2, 16'h8000, 1,
			{16'h0000, 1'b1, 14'h2000, 24'h000000});
		add_probe(ADDR_FROM_LOW, FMT_RGB4, KIND_ADDR, 2'd2, 16'h0fff, 1, '0);
		add_probe(ADDR_FROM_LOW, FMT_RGB4, KIND_DATA, 2'd2, 16'h0abc, 1,
			{16'h0000, 1'b1, 14'h2fff, 24'hccbbaa});
		add_probe(ADDR_FROM_LOW, FMT_RGB4, KIND_READ, 2'd2, 16'h0000, 1,
			{16'h0abc, 1'b0, 14'h0000, 24'h000000});
		add_probe(ADDR_FROM_LOW, FMT_RGB4, KIND_ADDR, 2'd0, 16'hf123, 1, '0);
		add_probe(ADDR_FROM_LOW, FMT_RGB4, KIND_DATA, 2'd0, 16'hffff, 1,
			{16'h0000, 1'b1, 14'h0123, 24'hffffff});
		add_probe(ADDR_FROM_LOW, FMT_BGR5, KIND_DATA, 2'd0, 16'h001f, 1,
			{16'h0000, 1'b1, 14'h0123, 24'h0000ff});
		add_probe(ADDR_FROM_LOW, FMT_BGR5, KIND_DATA, 2'd0, 16'h7c00, 1,
			{16'h0000, 1'b1, 14'h0123, 24'hff0000});
		// step value 2 keeps only bit 0; spare format decodes as 5-bit RGB
		add_probe(2'd2, FMT_SPARE, KIND_DATA, 2'd0, 16'h001f, 1,
			{16'h0000, 1'b1, 14'h0123, 24'hff0000});
		add_probe(2'd2, FMT_SPARE, KIND_ADDR, CHIP_ABSENT, 16'h1234, 1, '0);
		add_probe(2'd2, FMT_SPARE, KIND_ADDR, 2'd1, 16'h2468, 0, '0);
		add_probe(2'd2, FMT_SPARE, KIND_DATA, 2'd1, 16'h5a5a, 0, '0);
		add_probe(2'd2, FMT_SPARE, KIND_SPARE, 2'd1, 16'h0000, 1, '0);
		add_probe(2'd2, FMT_SPARE, KIND_READ, 2'd1, 16'hffff, 0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			if (probes[i].step != step_written || probes[i].fmt != fmt_written) begin
				settle();
				program_regs(probes[i].step, probes[i].fmt);
			end
			offer_access(probes[i].kind, probes[i].chip, probes[i].data,
				probes[i].pinned, probes[i].want);
		end

		for (int phase = 0; phase < 8; phase++) begin
			settle();
			step = (phase < 4) ? phase[1:0] & 2'd1 : 2'($urandom_range(0, 3));
			fmt = (phase < 4) ? fmt_t'(phase) : fmt_t'($urandom_range(0, 3));
			program_regs(step, fmt);
			no_idle = (phase == 2);
			if (phase == 5)
				hold_req = 1'b1;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				c = ($urandom_range(0, 99) < 8) ? CHIP_ABSENT : 2'($urandom_range(0, 2));
				d = 16'($urandom);
				if (pick < 4)
					k = KIND_SPARE;
				else if (pick < 28)
					k = KIND_READ;
				else if (pick < 52)
					k = KIND_ADDR;
				else
					k = KIND_DATA;
				// cluster addresses near both ends so reads hit written words
				if (k == KIND_ADDR && $urandom_range(0, 1) == 1) begin
					a = ($urandom_range(0, 1) == 1) ? 12'($urandom_range(0, 7))
						: 12'hff8 + 12'($urandom_range(0, 7));
					d = step_written[0] ? {4'($urandom), a} : {3'($urandom), a, 1'($urandom)};
				end
				offer_access(k, c, d, 1'b0, '0);
				counted++;
			end
		end

		no_idle = 1'b0;
		settle();
		repeat (10) @(posedge clk);
		fault_count += pending_results.size();
		if (fault_count == 0)
			$display("** palette_ram_color_expander: PASSED **");
		else
			$display("** palette_ram_color_expander: FAILED **");
		$finish;
	end

endmodule

[sim.f]
rtl/prce_pkg.sv
rtl/prce_in_if.sv
rtl/prce_out_if.sv
rtl/prce_ram.sv
rtl/prce_mod.sv
rtl/palette_ram_color_expander.sv
bench/palette_ram_color_expander_tb.sv
